// ----- src/touch_event_qualifier_queue_top_assert.svh -----
// Assertion macros for the touch event qualifier checker.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef TOUCH_EVENT_QUALIFIER_QUEUE_TOP_ASSERT_SVH
`define TOUCH_EVENT_QUALIFIER_QUEUE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TEVQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("touch event queue check failed");

// Consequent must hold in the cycle after the antecedent.
`define TEVQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("touch event queue check failed");

`endif

// ----- src/tevq_pkg.sv -----
// Shared types and constants for the touch event qualifier and queue.
// No dependencies; every module of the block imports this package.
`default_nettype none

package tevq_pkg;

   // Default sizes of the event queue and of one coordinate.
   localparam int QUEUE_DEPTH_DEFAULT = 32;
   localparam int COORD_BITS_DEFAULT  = 16;

   // Register file geometry.
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // Register reset values.
   localparam logic [15:0] RELEASE_TIMEOUT_RESET = 16'd80;
   localparam logic [4:0]  FAIL_LIMIT_RESET      = 5'd20;
   localparam logic [15:0] INIT_RETRY_RESET      = 16'd1000;
   localparam logic [15:0] POLL_MIN_RESET        = 16'd8000;
   localparam logic [15:0] POLL_MAX_RESET        = 16'd50000;

   // Register indexes (byte address divided by four).
   typedef enum logic [2:0] {
      REG_RELEASE_TIMEOUT = 3'd0,
      REG_FAIL_LIMIT      = 3'd1,
      REG_INIT_RETRY      = 3'd2,
      REG_POLL_MIN        = 3'd3,
      REG_POLL_MAX        = 3'd4
   } reg_index_type;

   // Item commands and controller read outcomes.
   localparam logic       CMD_POLL       = 1'b0;
   localparam logic       CMD_READ       = 1'b1;
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_DATA = 2'd1;
   localparam logic [1:0] STATUS_NO_RESP = 2'd2;

   typedef logic [15:0] coord_type;

   // Input word.
   typedef struct packed {
      logic        command;
      logic [31:0] now_ms;
      logic [1:0]  read_status;
      logic [2:0]  point_count;
      coord_type   point_x;
      coord_type   point_y;
      logic        release_hint;
      logic        init_ok;
   } req_type;

   // Result word.
   typedef struct packed {
      logic        event_valid;
      logic        event_pressed;
      coord_type   event_x;
      coord_type   event_y;
      logic        queue_nonempty;
      logic        wakeup;
      logic        link_down;
      logic [15:0] poll_interval_us;
   } rsp_type;

   // Queue operation requested for one accepted word.
   typedef struct packed {
      logic push;
      logic pop;
   } ring_op_type;

   // Queue status for the same word, valid in the cycle of the request.
   typedef struct packed {
      logic pop_hit;
      logic nonempty;
   } ring_stat_type;

endpackage

`default_nettype wire

// ----- src/touch_event_qualifier_queue_top.sv -----
// Touch event qualifier top level: link and press tracking, poll backoff and
// the register port. Depends on tevq_pkg and tevq_ring.
`default_nettype none

// The block takes one word per clock cycle while the result side keeps up,
// poll results and read requests alike, and gives exactly one result word for
// each, through the pipeline stage and then the output register. The rate rests
// on the registered update of the link and press registers and the registered
// read of the event memory; a result that waits on the output stops the next
// word from entering once the stage before it also holds one, and the output
// and that stage give room for two results. The event memory needs no clearing
// after reset. The user must write registers through the register port only
// while the block is idle; the block itself does not enforce it.
module touch_event_qualifier_queue_top
   import tevq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int COORD_BITS  = COORD_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_data,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic      [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                          csr_pready
);

   localparam int EV_BITS = 2 * COORD_BITS + 1;

   // Configuration registers.
   logic [15:0] release_timeout_ff;
   logic [4:0]  fail_limit_ff;
   logic [15:0] init_retry_ff;
   logic [15:0] poll_min_ff;
   logic [15:0] poll_max_ff;
   logic        csr_write;
   reg_index_type csr_index;

   // Qualifier state.
   logic                  link_ready_ff, link_ready_in;
   logic [31:0]           retry_at_ff, retry_at_in;
   logic [4:0]            fail_count_ff, fail_count_in;
   logic                  pressed_ff, pressed_in;
   logic [31:0]           last_touch_ff, last_touch_in;
   logic [COORD_BITS-1:0] last_x_ff, last_x_in;
   logic [COORD_BITS-1:0] last_y_ff, last_y_in;
   logic                  last_known_ff, last_known_in;
   logic [EV_BITS-1:0]    last_event_ff, last_event_in;
   logic [15:0]           interval_ff, interval_in;

   // Pipeline stage and output register.
   logic    accept;
   logic    pipe_move;
   logic    pipe_valid_ff, pipe_valid_in;
   rsp_type pipe_rsp_ff, pipe_rsp_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff, out_rsp_in;

   // Poll decode.
   logic                  is_read;
   logic [COORD_BITS-1:0] px, py;
   logic [32:0]           retry_sum;
   logic [31:0]           elapsed;
   logic                  no_resp;
   logic [4:0]            fail_next;
   logic                  lose;
   logic                  pressed_live;
   logic                  rel_timeout;
   logic                  rel_any;
   logic                  press;
   logic [EV_BITS-1:0]    ev;
   logic                  push_ev;
   logic                  wake;
   logic [16:0]           doubled;
   logic [15:0]           poll_out;

   ring_op_type        ring_op;
   ring_stat_type      ring_stat;
   logic [EV_BITS-1:0] ring_rd_data;

   // Handshake: the stage takes a word when it is empty or moving on.
   assign pipe_move = pipe_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !pipe_valid_ff || pipe_move;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_rsp_ff;

   // Register port: writes complete in the access phase, reads are plain.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_BITS-1:2]);

   always_comb begin
      case (csr_index)
         REG_RELEASE_TIMEOUT: csr_prdata = CSR_DATA_BITS'(release_timeout_ff);
         REG_FAIL_LIMIT:      csr_prdata = CSR_DATA_BITS'(fail_limit_ff);
         REG_INIT_RETRY:      csr_prdata = CSR_DATA_BITS'(init_retry_ff);
         REG_POLL_MIN:        csr_prdata = CSR_DATA_BITS'(poll_min_ff);
         REG_POLL_MAX:        csr_prdata = CSR_DATA_BITS'(poll_max_ff);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         release_timeout_ff <= RELEASE_TIMEOUT_RESET;
         fail_limit_ff      <= FAIL_LIMIT_RESET;
         init_retry_ff      <= INIT_RETRY_RESET;
         poll_min_ff        <= POLL_MIN_RESET;
         poll_max_ff        <= POLL_MAX_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_RELEASE_TIMEOUT: release_timeout_ff <= csr_pwdata[15:0];
            REG_FAIL_LIMIT:      fail_limit_ff      <= csr_pwdata[4:0];
            REG_INIT_RETRY:      init_retry_ff      <= csr_pwdata[15:0];
            REG_POLL_MIN:        poll_min_ff        <= csr_pwdata[15:0];
            REG_POLL_MAX:        poll_max_ff        <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Decode terms shared by the branches below.
   assign is_read   = (req_data.command == CMD_READ);
   assign px        = req_data.point_x[COORD_BITS-1:0];
   assign py        = req_data.point_y[COORD_BITS-1:0];
   assign retry_sum = {1'b0, req_data.now_ms} + {17'd0, init_retry_ff};
   assign elapsed   = req_data.now_ms - last_touch_ff;
   assign no_resp   = req_data.read_status[1];
   assign fail_next = no_resp ? fail_count_ff + 5'd1 : 5'd0;
   assign lose      = link_ready_ff && no_resp && (fail_next >= fail_limit_ff);

   // Press tracking while the link is ready. A poll makes at most one event:
   // either a release of the last point or a press at the new point.
   assign pressed_live = pressed_ff && !lose;
   assign rel_timeout  = pressed_live && (elapsed > {16'd0, release_timeout_ff});
   assign press = !(pressed_live && req_data.release_hint)
                  && (req_data.read_status == STATUS_OK)
                  && (req_data.point_count != 3'd0);
   assign rel_any = (lose && pressed_ff)
                    || (pressed_live && req_data.release_hint)
                    || (!press && rel_timeout);
   assign ev = rel_any ? {1'b0, last_x_ff, last_y_ff} : {1'b1, px, py};

   // Duplicate suppression against the last queued event.
   assign push_ev = !is_read && link_ready_ff && (rel_any || press)
                    && !(last_known_ff && (last_event_ff == ev));
   assign wake    = push_ev;
   assign doubled = {interval_ff, 1'b0};

   // Next state of the qualifier for one accepted word.
   always_comb begin
      link_ready_in = link_ready_ff;
      retry_at_in   = retry_at_ff;
      fail_count_in = fail_count_ff;
      pressed_in    = pressed_ff;
      last_touch_in = last_touch_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      last_known_in = last_known_ff;
      last_event_in = last_event_ff;
      interval_in   = interval_ff;
      poll_out      = interval_ff;
      if (!is_read) begin
         if (!link_ready_ff) begin
            // Init attempt once the retry time has come.
            if (req_data.now_ms >= retry_at_ff) begin
               if (req_data.init_ok) begin
                  link_ready_in = 1'b1;
                  fail_count_in = '0;
                  interval_in   = poll_min_ff;
               end else begin
                  retry_at_in = retry_sum[32] ? '1 : retry_sum[31:0];
               end
            end
            poll_out = poll_max_ff;
         end else begin
            fail_count_in = lose ? 5'd0 : fail_next;
            if (lose) begin
               link_ready_in = 1'b0;
               retry_at_in   = req_data.now_ms;
            end
            if (press) begin
               last_touch_in = req_data.now_ms;
               pressed_in    = 1'b1;
               last_x_in     = px;
               last_y_in     = py;
            end else if (rel_any) begin
               pressed_in = 1'b0;
            end
            if (push_ev) begin
               last_known_in = 1'b1;
               last_event_in = ev;
            end
            // Backoff: fast while active, otherwise doubling to the cap.
            if (wake || press || pressed_live) begin
               interval_in = poll_min_ff;
            end else if (interval_ff < poll_max_ff) begin
               interval_in = (doubled > {1'b0, poll_max_ff}) ? poll_max_ff : doubled[15:0];
            end
            poll_out = interval_in;
         end
      end
   end

   // Queue access for this word.
   assign ring_op.push = accept && push_ev;
   assign ring_op.pop  = accept && is_read;

   tevq_ring #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .COORD_BITS  (COORD_BITS)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .op         (ring_op),
      .push_data  (ev),
      .stat       (ring_stat),
      .rd_data_ff (ring_rd_data)
   );

   // Result fields known at acceptance; event fields follow from memory.
   always_comb begin
      pipe_rsp_in                  = '0;
      pipe_rsp_in.event_valid      = is_read && ring_stat.pop_hit;
      pipe_rsp_in.queue_nonempty   = ring_stat.nonempty;
      pipe_rsp_in.wakeup           = !is_read && wake;
      pipe_rsp_in.link_down        = !is_read && lose;
      pipe_rsp_in.poll_interval_us = poll_out;
   end

   always_comb begin
      out_rsp_in = pipe_rsp_ff;
      if (pipe_rsp_ff.event_valid) begin
         out_rsp_in.event_pressed = ring_rd_data[EV_BITS-1];
         out_rsp_in.event_x       = coord_type'(ring_rd_data[2*COORD_BITS-1:COORD_BITS]);
         out_rsp_in.event_y       = coord_type'(ring_rd_data[COORD_BITS-1:0]);
      end
   end

   assign pipe_valid_in = accept ? 1'b1 : (pipe_move ? 1'b0 : pipe_valid_ff);
   assign out_valid_in  = pipe_move ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ready_ff <= 1'b0;
         retry_at_ff   <= '0;
         fail_count_ff <= '0;
         pressed_ff    <= 1'b0;
         last_touch_ff <= '0;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         last_known_ff <= 1'b0;
         last_event_ff <= '0;
         interval_ff   <= POLL_MIN_RESET;
         pipe_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            link_ready_ff <= link_ready_in;
            retry_at_ff   <= retry_at_in;
            fail_count_ff <= fail_count_in;
            pressed_ff    <= pressed_in;
            last_touch_ff <= last_touch_in;
            last_x_ff     <= last_x_in;
            last_y_ff     <= last_y_in;
            last_known_ff <= last_known_in;
            last_event_ff <= last_event_in;
            interval_ff   <= interval_in;
         end
         pipe_valid_ff <= pipe_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         pipe_rsp_ff <= pipe_rsp_in;
      end
      if (pipe_move) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/tevq_ring.sv -----
// Event ring queue: a synchronous memory with write and read indexes that
// overwrites the oldest entry when full. Depends on tevq_pkg.
`default_nettype none

module tevq_ring
   import tevq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT,
   parameter int COORD_BITS  = COORD_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire ring_op_type             op,
   input  wire logic [2*COORD_BITS:0]   push_data,
   output ring_stat_type                stat,
   output logic      [2*COORD_BITS:0]   rd_data_ff
);

   localparam int IDX_BITS  = $clog2(2 * QUEUE_DEPTH);
   localparam int SLOT_BITS = $clog2(QUEUE_DEPTH);
   localparam int EV_BITS   = 2 * COORD_BITS + 1;
   localparam logic [IDX_BITS-1:0] DEPTH_IDX = IDX_BITS'(QUEUE_DEPTH);
   localparam logic [IDX_BITS-1:0] LAST_IDX  = IDX_BITS'(2 * QUEUE_DEPTH - 1);

   logic [EV_BITS-1:0]  mem [QUEUE_DEPTH];
   logic [IDX_BITS-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_BITS-1:0] count;
   logic                full;
   logic                do_read;

   // Indexes run over twice the depth so that full and empty differ.
   function automatic logic [IDX_BITS-1:0] next_idx(input logic [IDX_BITS-1:0] idx);
      return (idx == LAST_IDX) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [SLOT_BITS-1:0] slot_of(input logic [IDX_BITS-1:0] idx);
      logic [IDX_BITS-1:0] s;
      s = (idx >= DEPTH_IDX) ? idx - DEPTH_IDX : idx;
      return s[SLOT_BITS-1:0];
   endfunction

   // Fill level; when the write index is below the read index, twice the depth is added.
   always_comb begin
      if (wr_idx_ff >= rd_idx_ff) begin
         count = wr_idx_ff - rd_idx_ff;
      end else begin
         count = wr_idx_ff + IDX_BITS'(2 * QUEUE_DEPTH) - rd_idx_ff;
      end
   end

   assign full    = (count == DEPTH_IDX);
   assign do_read = op.pop && (count != '0);

   // Index updates: a push into a full queue drops the oldest entry.
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      if (op.push) begin
         wr_idx_in = next_idx(wr_idx_ff);
         if (full) begin
            rd_idx_in = next_idx(rd_idx_ff);
         end
      end else if (do_read) begin
         rd_idx_in = next_idx(rd_idx_ff);
      end
   end

   // Status after this operation.
   always_comb begin
      stat.pop_hit  = do_read;
      stat.nonempty = op.push || (op.pop ? (count > IDX_BITS'(1)) : (count != '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

   // Event memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (op.push) begin
         mem[slot_of(wr_idx_ff)] <= push_data;
      end
      if (do_read) begin
         rd_data_ff <= mem[slot_of(rd_idx_ff)];
      end
   end

endmodule

`default_nettype wire

// ----- src/tevq_checker.sv -----
// Port-level checks for the touch event qualifier, bound to the top level.
// Depends on tevq_pkg and the assertion macro header.
`default_nettype none

`include "touch_event_qualifier_queue_top_assert.svh"

module tevq_checker
   import tevq_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data,
   input wire logic    csr_psel,
   input wire logic    csr_pready
);

   // A result word that is not taken stays in place.
   `TEVQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Without a popped event the event fields read as zero.
   `TEVQ_ASSERT_SAME(a_empty_event_zero, rsp_valid && !rsp_data.event_valid,
      !rsp_data.event_pressed && (rsp_data.event_x == '0) && (rsp_data.event_y == '0))

   // A poll that queued an event leaves the queue occupied.
   `TEVQ_ASSERT_SAME(a_wake_nonempty, rsp_valid && rsp_data.wakeup, rsp_data.queue_nonempty)

   // A popped event comes from a read, which neither wakes nor drops the link.
   `TEVQ_ASSERT_SAME(a_pop_is_read, rsp_valid && rsp_data.event_valid,
      !rsp_data.wakeup && !rsp_data.link_down)

   // Register accesses never wait.
   `TEVQ_ASSERT_SAME(a_pready_high, csr_psel, csr_pready)

endmodule

bind touch_event_qualifier_queue_top tevq_checker u_tevq_checker (.*);

`default_nettype wire
